FILE: design/sfs_pkg.sv
package sfs_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    typedef struct packed {
        logic [7:0]  symbol;
        logic [31:0] frequency;
    } sfs_pair_t;

    // Chain control, broadcast from the top level to every cell
    typedef struct packed {
        logic      insert;
        logic      drain;
        sfs_pair_t new_pair;
    } sfs_ctl_t;

endpackage

FILE: design/sfs_in_if.sv
interface sfs_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  symbol;
    logic [31:0] frequency;
    logic        last_item;

    modport source (output valid, output symbol, output frequency, output last_item,
                    input ready);
    modport sink   (input valid, input symbol, input frequency, input last_item,
                    output ready);
endinterface

FILE: design/sfs_out_if.sv
interface sfs_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  sorted_symbol;
    logic [31:0] sorted_frequency;
    logic        last_result;
    logic        overflow;

    modport source (output valid, output sorted_symbol, output sorted_frequency,
                    output last_result, output overflow, input ready);
    modport sink   (input valid, input sorted_symbol, input sorted_frequency,
                    input last_result, input overflow, output ready);
endinterface

FILE: design/sfs_cell.sv
module sfs_cell
    import sfs_pkg::*;
(
    input  logic      clk,
    input  sfs_ctl_t  ctl,
    input  logic      occupied,
    input  sfs_pair_t prev_pair,
    input  logic      prev_cond,
    input  sfs_pair_t next_pair,
    output sfs_pair_t pair,
    output logic      cond
);

    sfs_pair_t pair_reg;
    sfs_pair_t pair_next;

    // Strict compare keeps equal frequencies in load order
    assign cond = !occupied || (pair_reg.frequency < ctl.new_pair.frequency);

    always_comb
    begin
        pair_next = pair_reg;
        if (ctl.drain)
        begin
            pair_next = next_pair;
        end
        else if (ctl.insert && cond)
        begin
            // shift down behind the insertion point, take the new pair at it
            pair_next = prev_cond ? prev_pair : ctl.new_pair;
        end
    end

    always_ff @(posedge clk)
    begin
        pair_reg <= pair_next;
    end

    assign pair = pair_reg;

endmodule

FILE: design/sfs_chain.sv
module sfs_chain
    import sfs_pkg::*;
(
    input  logic             clk,
    input  sfs_ctl_t         ctl,
    input  logic [CNT_W-1:0] count,
    output sfs_pair_t        head
);

    sfs_pair_t cell_pair [MAX_ENTRIES];
    logic      cell_cond [MAX_ENTRIES];

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++)
        begin : g_cell
            sfs_pair_t prev_pair;
            logic      prev_cond;
            sfs_pair_t next_pair;
            logic      occupied;

            assign occupied = (count > CNT_W'(g));

            if (g == 0)
            begin : g_first
                assign prev_pair = ctl.new_pair;
                assign prev_cond = 1'b0;
            end
            else
            begin : g_rest
                assign prev_pair = cell_pair[g-1];
                assign prev_cond = cell_cond[g-1];
            end

            if (g == MAX_ENTRIES - 1)
            begin : g_tail
                assign next_pair = cell_pair[g];
            end
            else
            begin : g_mid
                assign next_pair = cell_pair[g+1];
            end

            sfs_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .occupied  (occupied),
                .prev_pair (prev_pair),
                .prev_cond (prev_cond),
                .next_pair (next_pair),
                .pair      (cell_pair[g]),
                .cond      (cell_cond[g])
            );
        end
    endgenerate

    assign head = cell_pair[0];

endmodule

FILE: design/symbol_frequency_sorter.sv
// Stable descending sort of symbol/frequency pairs.
// The pairs channel takes one symbol/frequency request per cycle while the
// block is loading; a request with last_item set closes the set. Each pair is
// inserted at once into a row of sorting cells, so the row always holds the
// pairs ordered by descending frequency, ties in load order.
// Once the closing request is taken, pairs.ready drops and the results channel
// presents the head of the row in the next cycle: one result per stored pair,
// one per cycle while results.ready is high, last_result on the final one and
// overflow on every result of a set that lost pairs. The row holds
// MAX_ENTRIES pairs, and pairs beyond that are dropped. The drain rate is set
// by the single shift of the row per result.
// While results.ready is low the row and the presented result hold. After the
// final result is taken the block returns to loading with an empty row.
// Reset empties the row and clears the overflow flag; no clearing pass runs,
// so the block is ready to load right after reset.
module symbol_frequency_sorter
    import sfs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sfs_in_if.sink        pairs,
    sfs_out_if.source     results
);

    localparam logic ST_LOAD  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic             state_reg;
    logic             state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;

    logic             in_fire;
    logic             out_fire;
    logic             full;
    sfs_ctl_t         ctl;
    sfs_pair_t        head;

    assign full     = (count_reg == CNT_W'(MAX_ENTRIES));
    assign in_fire  = pairs.valid && pairs.ready;
    assign out_fire = results.valid && results.ready;

    assign ctl.insert   = in_fire && !full;
    assign ctl.drain    = out_fire;
    assign ctl.new_pair = '{symbol: pairs.symbol, frequency: pairs.frequency};

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (pairs.last_item)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_fire)
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next = ST_LOAD;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    sfs_chain u_chain (
        .clk   (clk),
        .ctl   (ctl),
        .count (count_reg),
        .head  (head)
    );

    assign pairs.ready              = (state_reg == ST_LOAD);
    assign results.valid            = (state_reg == ST_DRAIN);
    assign results.sorted_symbol    = head.symbol;
    assign results.sorted_frequency = head.frequency;
    assign results.last_result      = (count_reg == CNT_W'(1));
    assign results.overflow         = ovf_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count exceeds capacity");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> count_reg != '0)
        else $error("draining an empty row");

    a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && pairs.last_item) |=> results.valid)
        else $error("closing request did not start the drain");

    a_drop_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && full) |=> ovf_reg)
        else $error("dropped pair not flagged");

    a_final_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && results.last_result) |=> (pairs.ready && !ovf_reg
                                                && count_reg == '0))
        else $error("block not rearmed after final result");

endmodule
